// ----- hw/rtl/frame_header_deframer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Frame header deframer assertion macros
// Shared property wrappers used by the deframer modules. Defining
// NO_ASSERTIONS turns every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef FRAME_HEADER_DEFRAMER_CORE_ASSERT_SVH
`define FRAME_HEADER_DEFRAMER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define FHD_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define FHD_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define FHD_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define FHD_ASSERT_NXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ----- hw/rtl/fhd_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame header deframer package
// Types, codes and constants shared by the deframer modules and interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package fhd_pkg;

    localparam int HDR_LEN   = 20;
    localparam int HDR_IDX_W = $clog2(HDR_LEN);
    // The first HDR_LEN-1 header bytes wait in a shift line; the last one
    // arrives with the item that completes the header.
    localparam int HDR_SR_W  = (HDR_LEN - 1) * 8;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_LEN - 1);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_VERSION = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_SIZE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CALLER_LIMIT     = 8'd3;

    localparam logic [31:0] FRAME_MAGIC_RST      = 32'd0;
    localparam logic [15:0] PROTOCOL_VERSION_RST = 16'd1;
    localparam logic [31:0] MAX_FRAME_SIZE_RST   = 32'd16777216;
    localparam logic [31:0] CALLER_LIMIT_RST     = 32'd0;

    // Result queue: one item can push two results, so room means two free slots.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_ROOM_MAX = QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL     = QUEUE_CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DESC = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_CLOSED_HDR     = 3'd1,
        ERR_MAGIC          = 3'd2,
        ERR_VERSION        = 3'd3,
        ERR_OVERSIZED      = 3'd4,
        ERR_CALLER         = 3'd5,
        ERR_CLOSED_PAYLOAD = 3'd6
    } err_t;

    typedef struct packed {
        logic [31:0] frame_magic;
        logic [15:0] protocol_version;
        logic [31:0] max_frame_size;
        logic [31:0] caller_limit;
    } cfg_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  msg_type;
        logic [7:0]  frame_flags;
        logic [63:0] correlation;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        err_t        error_code;
    } res_t;

    // push1 always carries the closed-in-payload error after the first result.
    typedef struct packed {
        logic push0;
        logic push1;
        res_t res;
    } push_t;

    function automatic res_t err_result(input err_t code);
        res_t r;
        r             = '0;
        r.result_kind = KIND_ERR;
        r.last        = 1'b1;
        r.error_code  = code;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fhd_in_if.sv -----
// ----------------------------------------------------------------------------
// Deframer byte stream channel
// One stream byte per item with the end-of-stream flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       stream_end;

    modport source (output valid, output data_in, output stream_end, input ready);
    modport sink   (input valid, input data_in, input stream_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fhd_out_if.sv -----
// ----------------------------------------------------------------------------
// Deframer result channel
// Header descriptors, payload bytes and errors, one per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhd_out_if;
    import fhd_pkg::*;

    logic        valid;
    logic        ready;
    kind_t       result_kind;
    logic [7:0]  msg_type;
    logic [7:0]  frame_flags;
    logic [63:0] correlation;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    err_t        error_code;

    modport source (output valid, output result_kind, output msg_type, output frame_flags,
                    output correlation, output payload_length, output payload_byte,
                    output last, output error_code, input ready);
    modport sink   (input valid, input result_kind, input msg_type, input frame_flags,
                    input correlation, input payload_length, input payload_byte,
                    input last, input error_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fhd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Deframer configuration write channel
// Register index and write data, one register write per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhd_cfg_if;
    import fhd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frame_header_deframer_core.sv -----
// ----------------------------------------------------------------------------
// Frame header deframer core
// Splits a byte stream into length-prefixed frames: a 20-byte big-endian
// header is checked and reported as a descriptor or an error, followed by
// the payload bytes of the frame.
//
//   Channel   Dir   Handshake      Payload
//   stream    in    valid/ready    data_in, stream_end
//   result    out   valid/ready    result_kind .. error_code (descriptor,
//                                  payload byte or error)
//   cfg       in    valid/ready    reg_index, wdata (always ready)
//
// One stream byte is taken every cycle while the result queue has two free
// slots; the parser works on it in the cycle it is accepted and its results
// are registered in the result queue, which drives the result channel.
// The four-entry result queue sets the rate under output stalls: input
// stalls only when fewer than two slots are free.
// Reset clears the phase, header index, byte count and queue; config
// registers return to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_header_deframer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    fhd_in_if.sink    stream,
    fhd_out_if.source result,
    fhd_cfg_if.sink   cfg
);
    import fhd_pkg::*;

    cfg_t  cfg_reg;
    push_t push;
    logic  room;
    logic  head_valid;
    res_t  head;
    logic  accept;

    assign cfg.ready    = 1'b1;
    assign stream.ready = room;
    assign accept       = stream.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_magic      <= FRAME_MAGIC_RST;
            cfg_reg.protocol_version <= PROTOCOL_VERSION_RST;
            cfg_reg.max_frame_size   <= MAX_FRAME_SIZE_RST;
            cfg_reg.caller_limit     <= CALLER_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_FRAME_MAGIC:      cfg_reg.frame_magic      <= cfg.wdata;
                REG_PROTOCOL_VERSION: cfg_reg.protocol_version <= cfg.wdata[15:0];
                REG_MAX_FRAME_SIZE:   cfg_reg.max_frame_size   <= cfg.wdata;
                REG_CALLER_LIMIT:     cfg_reg.caller_limit     <= cfg.wdata;
                default:              ;
            endcase
        end
    end

    fhd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_in    (stream.data_in),
        .stream_end (stream.stream_end),
        .cfg        (cfg_reg),
        .push       (push)
    );

    fhd_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop_ready  (result.ready)
    );

    assign result.valid          = head_valid;
    assign result.result_kind    = head.result_kind;
    assign result.msg_type       = head.msg_type;
    assign result.frame_flags    = head.frame_flags;
    assign result.correlation    = head.correlation;
    assign result.payload_length = head.payload_length;
    assign result.payload_byte   = head.payload_byte;
    assign result.last           = head.last;
    assign result.error_code     = head.error_code;

endmodule

`default_nettype wire

// ----- hw/rtl/fhd_parser.sv -----
// ----------------------------------------------------------------------------
// Deframer parser
// Header collection, header checks, payload counting and drop handling.
// Produces up to two results for each accepted stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_header_deframer_core_assert.svh"

module fhd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    data_in,
    input  wire logic          stream_end,
    input  wire fhd_pkg::cfg_t cfg,
    output fhd_pkg::push_t     push
);
    import fhd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [31:0]            remain_reg, remain_next;
    logic [HDR_SR_W-1:0]    hdr_sr_reg;
    logic                   hdr_shift;

    logic [HDR_SR_W+7:0]    hdr;
    logic [31:0]            hdr_magic;
    logic [15:0]            hdr_version;
    logic [31:0]            hdr_len;
    err_t                   check_code;
    logic                   data_fin;

    // Full header as seen on the byte that completes it, oldest byte on top.
    assign hdr         = {hdr_sr_reg, data_in};
    assign hdr_magic   = hdr[159:128];
    assign hdr_version = hdr[127:112];
    assign hdr_len     = hdr[31:0];

    always_comb
    begin
        priority if (hdr_magic != cfg.frame_magic)
            check_code = ERR_MAGIC;
        else if (hdr_version != cfg.protocol_version)
            check_code = ERR_VERSION;
        else if (hdr_len > cfg.max_frame_size)
            check_code = ERR_OVERSIZED;
        else if (cfg.caller_limit != 32'd0 && hdr_len > cfg.caller_limit)
            check_code = ERR_CALLER;
        else
            check_code = ERR_NONE;
    end

    // A count of zero in the payload phase is treated as one byte left.
    assign data_fin = (remain_reg <= 32'd1);

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        remain_next  = remain_reg;
        hdr_shift    = 1'b0;
        push         = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_shift = 1'b1;
                    if (hdr_idx_reg != HDR_LAST_IDX)
                    begin
                        if (stream_end)
                        begin
                            hdr_idx_next = '0;
                            push.push0   = 1'b1;
                            push.res     = err_result(ERR_CLOSED_HDR);
                        end
                        else
                        begin
                            hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
                        end
                    end
                    else
                    begin
                        hdr_idx_next = '0;
                        push.push0   = 1'b1;
                        if (check_code != ERR_NONE)
                        begin
                            push.res   = err_result(check_code);
                            phase_next = stream_end ? PH_HEADER : PH_DROP;
                        end
                        else
                        begin
                            push.res.result_kind    = KIND_DESC;
                            push.res.msg_type       = hdr[111:104];
                            push.res.frame_flags    = hdr[103:96];
                            push.res.correlation    = hdr[95:32];
                            push.res.payload_length = hdr_len;
                            push.res.last           = (hdr_len == 32'd0);
                            if (hdr_len != 32'd0)
                            begin
                                if (stream_end)
                                begin
                                    push.push1 = 1'b1;
                                end
                                else
                                begin
                                    remain_next = hdr_len;
                                    phase_next  = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    push.push0             = 1'b1;
                    push.res.result_kind   = KIND_DATA;
                    push.res.payload_byte  = data_in;
                    push.res.last          = data_fin;
                    if (data_fin)
                    begin
                        remain_next = '0;
                        phase_next  = PH_HEADER;
                    end
                    else if (stream_end)
                    begin
                        push.push1  = 1'b1;
                        remain_next = '0;
                        phase_next  = PH_HEADER;
                    end
                    else
                    begin
                        remain_next = remain_reg - 32'd1;
                    end
                end
                default:
                begin
                    // Drop phase: bytes vanish until the stream closes.
                    if (stream_end)
                    begin
                        phase_next   = PH_HEADER;
                        hdr_idx_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            remain_reg  <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_shift)
        begin
            hdr_sr_reg <= {hdr_sr_reg[HDR_SR_W-9:0], data_in};
        end
    end

    `FHD_ASSERT_IMP(a_hdr_idx_range, clk, rst_n, 1'b1, hdr_idx_reg <= HDR_LAST_IDX)
    `FHD_ASSERT_IMP(a_payload_count, clk, rst_n, phase_reg == PH_PAYLOAD, remain_reg != 32'd0)
    `FHD_ASSERT_IMP(a_second_result, clk, rst_n, push.push1, push.push0 && push.res.result_kind != KIND_ERR && !push.res.last)
    `FHD_ASSERT_NXT(a_payload_leaves, clk, rst_n, accept && phase_reg == PH_PAYLOAD && stream_end, phase_reg == PH_HEADER)

endmodule

`default_nettype wire

// ----- hw/rtl/fhd_result_queue.sv -----
// ----------------------------------------------------------------------------
// Deframer result queue
// Small register queue that takes up to two results a cycle and hands one
// result a cycle to the output channel while that channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_header_deframer_core_assert.svh"

module fhd_result_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fhd_pkg::push_t push,
    output logic                room,
    output logic                head_valid,
    output fhd_pkg::res_t       head,
    input  wire logic           pop_ready
);
    import fhd_pkg::*;

    res_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   pop;

    assign room       = (count_reg <= QUEUE_ROOM_MAX);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.push0) + QUEUE_PTR_W'(push.push1);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push.push0) + QUEUE_CNT_W'(push.push1)
                      - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_ptr_reg] <= push.res;
        end
        if (push.push1)
        begin
            entry_reg[wr_ptr_reg + QUEUE_PTR_W'(1)] <= err_result(ERR_CLOSED_PAYLOAD);
        end
    end

    `FHD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= QUEUE_FULL)
    `FHD_ASSERT_IMP(a_push_needs_room, clk, rst_n, push.push0, room)
    `FHD_ASSERT_IMP(a_push_order, clk, rst_n, push.push1, push.push0)
    `FHD_ASSERT_NXT(a_pop_only, clk, rst_n, pop && !push.push0, count_reg == $past(count_reg) - QUEUE_CNT_W'(1))

endmodule

`default_nettype wire

// ----- test/frame_header_deframer_checker.sv -----
// ----------------------------------------------------------------------------
// Frame header deframer result checker
// Watches the byte stream, result and configuration channels of the deframer.
// Every accepted stream byte runs through a local copy of the header parser,
// and the results it predicts wait in order until the block delivers them.
// Each delivered result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module frame_header_deframer_checker (
    input  logic clk,
    input  logic rst_n,
    fhd_in_if    byte_ch,
    fhd_out_if   res_ch,
    fhd_cfg_if   cfg_ch,
    output int   mismatches,
    output int   results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import fhd_pkg::*;

    // Local copy of the parser state and of the register file.
    phase_t      ph;
    int          hdr_cnt;
    logic [7:0]  hdr [HDR_LEN];
    logic [31:0] remaining;
    cfg_t        limits;

    res_t        frame_results_due [$];

    function automatic res_t frame_result(input kind_t kind, input logic last,
                                          input err_t code);
        res_t r;
        r             = '0;
        r.result_kind = kind;
        r.last        = last;
        r.error_code  = code;
        return r;
    endfunction

    // Appends a predicted result behind the ones still waiting.
    function automatic void queue_result(input res_t r);
        frame_results_due.insert(frame_results_due.size(), r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic close);
        logic [31:0] len;
        err_t        code;
        res_t        r;
        case (ph)
            PH_HEADER:
            begin
                hdr[hdr_cnt] = b;
                hdr_cnt++;
                if (hdr_cnt < HDR_LEN)
                begin
                    if (close)
                    begin
                        hdr_cnt = 0;
                        queue_result(frame_result(KIND_ERR, 1'b1, ERR_CLOSED_HDR));
                    end
                end
                else
                begin
                    hdr_cnt = 0;
                    len     = {hdr[16], hdr[17], hdr[18], hdr[19]};
                    code    = ERR_NONE;
                    // The checks are ordered: the first failing one is reported.
                    if ({hdr[0], hdr[1], hdr[2], hdr[3]} != limits.frame_magic)
                        code = ERR_MAGIC;
                    else if ({hdr[4], hdr[5]} != limits.protocol_version)
                        code = ERR_VERSION;
                    else if (len > limits.max_frame_size)
                        code = ERR_OVERSIZED;
                    else if (limits.caller_limit != 0 && len > limits.caller_limit)
                        code = ERR_CALLER;

                    if (code != ERR_NONE)
                    begin
                        ph = close ? PH_HEADER : PH_DROP;
                        queue_result(frame_result(KIND_ERR, 1'b1, code));
                    end
                    else
                    begin
                        r                = frame_result(KIND_DESC, len == 0, ERR_NONE);
                        r.msg_type       = hdr[6];
                        r.frame_flags    = hdr[7];
                        r.correlation    = {hdr[8], hdr[9], hdr[10], hdr[11],
                                            hdr[12], hdr[13], hdr[14], hdr[15]};
                        r.payload_length = len;
                        queue_result(r);
                        if (len != 0)
                        begin
                            if (close)
                                queue_result(
                                    frame_result(KIND_ERR, 1'b1, ERR_CLOSED_PAYLOAD));
                            else
                            begin
                                remaining = len;
                                ph        = PH_PAYLOAD;
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                remaining--;
                r              = frame_result(KIND_DATA, remaining == 0, ERR_NONE);
                r.payload_byte = b;
                queue_result(r);
                if (remaining == 0)
                    ph = PH_HEADER;
                else if (close)
                begin
                    ph        = PH_HEADER;
                    remaining = '0;
                    queue_result(frame_result(KIND_ERR, 1'b1, ERR_CLOSED_PAYLOAD));
                end
            end
            default:
            begin
                // Dropping bytes after a bad header until the stream closes.
                if (close)
                begin
                    ph      = PH_HEADER;
                    hdr_cnt = 0;
                end
            end
        endcase
    endfunction

    function automatic int field_diff(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int   bad;
        res_t want;
        bad = 0;
        if (!rst_n)
        begin
            ph          = PH_HEADER;
            hdr_cnt     = 0;
            remaining   = '0;
            limits      = {FRAME_MAGIC_RST, PROTOCOL_VERSION_RST,
                           MAX_FRAME_SIZE_RST, CALLER_LIMIT_RST};
            frame_results_due.delete();
            mismatches  <= 0;
            results_due <= 0;
        end
        else
        begin
            // Results are compared before this edge's byte is parsed, so a
            // result can never be matched against its own prediction early.
            if (res_ch.valid && res_ch.ready)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d",
                             $time, res_ch.result_kind);
                    bad++;
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    bad += field_diff("result_kind", want.result_kind, res_ch.result_kind);
                    bad += field_diff("msg_type", want.msg_type, res_ch.msg_type);
                    bad += field_diff("frame_flags", want.frame_flags, res_ch.frame_flags);
                    bad += field_diff("correlation", want.correlation, res_ch.correlation);
                    bad += field_diff("payload_length", want.payload_length,
                                      res_ch.payload_length);
                    bad += field_diff("payload_byte", want.payload_byte, res_ch.payload_byte);
                    bad += field_diff("last", want.last, res_ch.last);
                    bad += field_diff("error_code", want.error_code, res_ch.error_code);
                end
            end

            // A byte taken at the same edge as a register write still sees
            // the old register value.
            if (byte_ch.valid && byte_ch.ready)
                deframe_byte(byte_ch.data_in, byte_ch.stream_end);

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.reg_index)
                    REG_FRAME_MAGIC:      limits.frame_magic      = cfg_ch.wdata;
                    REG_PROTOCOL_VERSION: limits.protocol_version = cfg_ch.wdata[15:0];
                    REG_MAX_FRAME_SIZE:   limits.max_frame_size   = cfg_ch.wdata;
                    REG_CALLER_LIMIT:     limits.caller_limit     = cfg_ch.wdata;
                    default: ;
                endcase
            end

            mismatches  <= mismatches + bad;
            results_due <= frame_results_due.size();
        end
    end

endmodule

// ----- test/frame_header_deframer_core_test.sv -----
// ----------------------------------------------------------------------------
// Frame header deframer testbench
// Feeds the deframer directed frames for every header check and every way a
// stream can close, then random sessions of mostly well-formed frames under
// changing register settings. Both the byte sender and the result receiver
// stall at random. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module frame_header_deframer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fhd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_GAP       = 12;
    localparam int RANDOM_BYTES  = 600;
    localparam int SESSION_BYTES = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(4);

    logic clk;
    logic rst_n = 1'b0;
    int   mismatches;
    int   results_due;
    int   cycles = 0;
    int   sent_bytes = 0;
    bit   steady_in = 1'b0;
    bit   steady_out = 1'b0;

    // Settings currently in the block, used to build well-formed headers.
    logic [31:0] cur_magic  = FRAME_MAGIC_RST;
    logic [15:0] cur_ver    = PROTOCOL_VERSION_RST;
    logic [31:0] cur_max    = MAX_FRAME_SIZE_RST;
    logic [31:0] cur_caller = CALLER_LIMIT_RST;

    fhd_in_if  byte_ch ();
    fhd_out_if result_ch ();
    fhd_cfg_if cfg_ch ();

    frame_header_deframer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    frame_header_deframer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_ch     (byte_ch),
        .res_ch      (result_ch),
        .cfg_ch      (cfg_ch),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Result receiver: random stalls, with stretches of constant readiness.
    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                steady_out = !steady_out;
            gap = draw_gap(steady_out);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [7:0] b, input logic close);
        int gap;
        if ($urandom_range(0, 49) == 0)
            steady_in = !steady_in;
        gap = draw_gap(steady_in);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_in    <= b;
        byte_ch.stream_end <= close;
        do @(posedge clk); while (!byte_ch.ready);
        sent_bytes++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [31:0] max_len, input logic [31:0] caller,
                              input bit stray);
        if (stray)
            write_reg(REG_UNMAPPED, $urandom);
        write_reg(REG_FRAME_MAGIC, magic);
        // Upper bits of the version write are don't-care and get random values.
        write_reg(REG_PROTOCOL_VERSION, {16'($urandom), ver});
        write_reg(REG_MAX_FRAME_SIZE, max_len);
        write_reg(REG_CALLER_LIMIT, caller);
        cfg_ch.valid <= 1'b0;
        cur_magic  = magic;
        cur_ver    = ver;
        cur_max    = max_len;
        cur_caller = caller;
    endtask

    // Holds the stream until every predicted result has been delivered and
    // the parser has had time to settle.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sends the first hdr_cut header bytes; a complete header is followed by
    // body random bytes. With close the final byte sent ends the stream.
    task automatic drive_frame(input logic [31:0] magic, input logic [15:0] ver,
                               input logic [31:0] len, input int hdr_cut,
                               input int body, input bit close);
        logic [HDR_LEN*8-1:0] hdr_bits;
        logic [7:0]           b;
        int                   total;
        hdr_bits = {magic, ver, 8'($urandom), 8'($urandom), $urandom, $urandom, len};
        total    = (hdr_cut < HDR_LEN) ? hdr_cut : HDR_LEN + body;
        for (int i = 0; i < total; i++)
        begin
            b = (i < HDR_LEN) ? hdr_bits[(HDR_LEN - 1 - i) * 8 +: 8] : 8'($urandom);
            send_byte(b, close && (i == total - 1));
        end
    endtask

    task automatic random_frame();
        int          pick;
        int          body;
        int          lim;
        logic [31:0] len;
        logic [31:0] magic;
        logic [15:0] ver;
        bit          close;
        pick  = $urandom_range(0, 99);
        magic = cur_magic;
        ver   = cur_ver;
        lim   = 12;
        if (cur_max < lim)
            lim = cur_max;
        if (cur_caller != 0 && cur_caller < lim)
            lim = cur_caller;
        len   = $urandom_range(0, lim);
        body  = len;
        close = ($urandom_range(0, 5) == 0);
        if (pick < 70)
        begin
            // Well-formed; now and then the stream closes inside the payload.
            if (len != 0 && $urandom_range(0, 7) == 0)
            begin
                body  = $urandom_range(0, len - 1);
                close = 1'b1;
            end
        end
        else if (pick < 80)
        begin
            if ($urandom_range(0, 1) == 1)
                magic = magic ^ (32'd1 << $urandom_range(0, 31));
            else
                ver = ver ^ (16'd1 << $urandom_range(0, 15));
            body  = $urandom_range(0, 4);
            close = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 90)
        begin
            if (cur_max < 32'hFFFF_FFF0)
                len = cur_max + 1 + $urandom_range(0, 3);
            else if (cur_caller != 0 && cur_caller != 32'hFFFF_FFFF)
                len = cur_caller + 1;
            else
                len = $urandom;
            body  = $urandom_range(0, 4);
            close = 1'b1;
        end
        else if (pick < 95)
        begin
            drive_frame(magic, ver, len, $urandom_range(1, HDR_LEN - 1), 0, 1'b1);
            return;
        end
        else
        begin
            repeat ($urandom_range(1, 30))
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        drive_frame(magic, ver, len, HDR_LEN, body, close);
    endtask

    initial
    begin : stimulus
        int          session_end;
        int          random_end;
        logic [31:0] m;
        logic [31:0] mx;
        logic [31:0] cl;
        logic [15:0] v;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_in    <= '0;
        byte_ch.stream_end <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.reg_index   <= '0;
        cfg_ch.wdata       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset settings.
        drive_frame(32'd0, 16'd1, 32'd3, HDR_LEN, 3, 1'b0);
        drive_frame(32'd0, 16'd1, 32'd0, HDR_LEN, 0, 1'b0);
        drive_frame(32'd0, 16'd1, 32'd2, HDR_LEN, 2, 1'b1);
        drive_frame(32'd0, 16'd1, 32'd0, HDR_LEN, 0, 1'b1);
        drive_frame(32'd0, 16'd1, 32'd5, HDR_LEN, 0, 1'b1);
        drive_frame(32'd0, 16'd1, 32'd4, HDR_LEN, 2, 1'b1);
        drive_frame(32'd0, 16'd1, 32'd0, 1, 0, 1'b1);
        drive_frame(32'd0, 16'd1, 32'd0, HDR_LEN - 1, 0, 1'b1);
        drive_frame(32'd1, 16'd1, 32'd3, HDR_LEN, 3, 1'b1);
        drive_frame(32'd0, 16'd2, 32'd3, HDR_LEN, 0, 1'b1);
        drive_frame(32'd0, 16'd1, MAX_FRAME_SIZE_RST + 1, HDR_LEN, 2, 1'b0);
        // Still dropping: this whole frame vanishes up to its closing byte.
        drive_frame(32'd0, 16'd1, 32'd3, HDR_LEN, 3, 1'b1);
        wait_idle();

        set_config(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd5, 1'b1);
        drive_frame(32'hFFFF_FFFF, 16'hFFFF, 32'd6, HDR_LEN, 0, 1'b1);
        drive_frame(32'hFFFF_FFFF, 16'hFFFF, 32'd5, HDR_LEN, 5, 1'b0);
        wait_idle();

        set_config(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
        drive_frame(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, HDR_LEN, 3, 1'b1);
        wait_idle();

        set_config(32'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        drive_frame(32'd0, 16'd0, 32'd0, HDR_LEN, 0, 1'b0);
        drive_frame(32'd0, 16'd0, 32'd1, HDR_LEN, 0, 1'b1);
        // Bad magic, bad version and oversized at once: magic wins.
        drive_frame(32'h8000_0000, 16'd1, 32'd1, HDR_LEN, 0, 1'b1);

        // Random sessions, each under fresh settings and closed at its end.
        random_end = sent_bytes + RANDOM_BYTES;
        while (sent_bytes < random_end)
        begin
            wait_idle();
            case ($urandom_range(0, 2))
                0:       m = 32'd0;
                1:       m = 32'hFFFF_FFFF;
                default: m = $urandom;
            endcase
            case ($urandom_range(0, 2))
                0:       v = 16'd0;
                1:       v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       mx = 32'd0;
                1:       mx = 32'd8;
                2:       mx = 32'd64;
                3:       mx = MAX_FRAME_SIZE_RST;
                4:       mx = 32'hFFFF_FFFF;
                default: mx = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 4))
                0, 1:    cl = 32'd0;
                2:       cl = 32'd5;
                3:       cl = 32'd12;
                default: cl = 32'hFFFF_FFFF;
            endcase
            set_config(m, v, mx, cl, $urandom_range(0, 3) == 0);
            session_end = sent_bytes + SESSION_BYTES;
            while (sent_bytes < session_end)
                random_frame();
            send_byte(8'($urandom), 1'b1);
        end

        wait_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
